// ===== design/jfd_pkg.sv =====
// Package for the JSON frame delimiter: byte codes, limit constants,
// scanner modes and the result record passed between the modules.
// No dependencies.
package jfd_pkg;

  localparam int unsigned LIMIT_W = 26;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 26'h200_0000;
  localparam logic [LIMIT_W-1:0] COUNT_ONE   = 26'd1;
  localparam logic [LIMIT_W-1:0] COUNT_ZERO  = 26'd0;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [3:0] {
    MODE_HUNT  = 4'b0001,
    MODE_FRAME = 4'b0010,
    MODE_STR   = 4'b0100,
    MODE_ESC   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_first;
    logic       frame_last;
    logic       frame_error;
  } res_t;

endpackage

// ===== design/jfd_in_reg.sv =====
// Input register of the JSON frame delimiter: holds one received byte
// until the scanner takes it. Depends on nothing but the clock and reset.
module jfd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       advance,
  output logic       hold_vld,
  output logic [7:0] hold_byte
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       take;

  assign in_stall  = vld_r && !advance;
  assign take      = in_valid && !in_stall;
  assign hold_vld  = vld_r;
  assign hold_byte = byte_r;

  always_comb begin
    priority if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload: load on transfer
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ===== design/jfd_scan.sv =====
// Scanner of the JSON frame delimiter: mode, depth, opener type, byte
// count and length limit, with the per-byte framing decision.
// Depends on jfd_pkg.
module jfd_scan #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [jfd_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic                      go,
  input  logic [7:0]                rx_byte,
  output logic                      res_vld,
  output jfd_pkg::res_t             res
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE  = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
  localparam logic [DEPTH_BITS-1:0] DEPTH_NONE = {DEPTH_BITS{1'b0}};

  jfd_pkg::mode_t mode_r, mode_nxt;
  logic [DEPTH_BITS-1:0]         depth_r, depth_nxt;
  logic                          brace_r, brace_nxt;
  logic [jfd_pkg::LIMIT_W-1:0]   count_r, count_nxt;
  logic [jfd_pkg::LIMIT_W-1:0]   max_len_r;

  logic [7:0] open_ch;
  logic [7:0] shut_ch;
  logic       is_opener;
  logic       at_limit;
  logic       abort;
  logic       pass;

  assign open_ch   = brace_r ? jfd_pkg::CH_LBRACE : jfd_pkg::CH_LBRACKET;
  assign shut_ch   = brace_r ? jfd_pkg::CH_RBRACE : jfd_pkg::CH_RBRACKET;
  assign is_opener = (rx_byte == jfd_pkg::CH_LBRACE) || (rx_byte == jfd_pkg::CH_LBRACKET);
  assign at_limit  = count_r >= max_len_r;

  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    brace_nxt = brace_r;
    count_nxt = count_r;
    res_vld   = 1'b0;
    res       = '0;
    abort     = 1'b0;
    pass      = 1'b0;

    unique case (mode_r)
      jfd_pkg::MODE_HUNT: begin
        if (is_opener) begin
          res_vld = 1'b1;
          if (max_len_r == jfd_pkg::COUNT_ZERO) begin
            abort = 1'b1;
          end else begin
            brace_nxt       = (rx_byte == jfd_pkg::CH_LBRACE);
            depth_nxt       = DEPTH_ONE;
            count_nxt       = jfd_pkg::COUNT_ONE;
            mode_nxt        = jfd_pkg::MODE_FRAME;
            res.frame_byte  = rx_byte;
            res.frame_first = 1'b1;
          end
        end
      end
      jfd_pkg::MODE_FRAME: begin
        res_vld = 1'b1;
        pass    = 1'b1;
        if (at_limit) begin
          abort = 1'b1;
        end else if (rx_byte == open_ch) begin
          if (depth_r == DEPTH_FULL) begin
            abort = 1'b1;
          end else begin
            depth_nxt = depth_r + DEPTH_ONE;
          end
        end else if (rx_byte == shut_ch) begin
          depth_nxt = depth_r - DEPTH_ONE;
          if (depth_nxt == DEPTH_NONE) begin
            mode_nxt       = jfd_pkg::MODE_HUNT;
            pass           = 1'b0;
            count_nxt      = jfd_pkg::COUNT_ZERO;
            res.frame_byte = rx_byte;
            res.frame_last = 1'b1;
          end
        end else if (rx_byte == jfd_pkg::CH_QUOTE) begin
          mode_nxt = jfd_pkg::MODE_STR;
        end
      end
      jfd_pkg::MODE_STR: begin
        res_vld = 1'b1;
        pass    = 1'b1;
        if (at_limit) begin
          abort = 1'b1;
        end else if (rx_byte == jfd_pkg::CH_BACKSLASH) begin
          mode_nxt = jfd_pkg::MODE_ESC;
        end else if (rx_byte == jfd_pkg::CH_QUOTE) begin
          mode_nxt = jfd_pkg::MODE_FRAME;
        end
      end
      jfd_pkg::MODE_ESC: begin
        res_vld = 1'b1;
        pass    = 1'b1;
        if (at_limit) begin
          abort = 1'b1;
        end else begin
          mode_nxt = jfd_pkg::MODE_STR;
        end
      end
      default: begin
        mode_nxt = jfd_pkg::MODE_HUNT;
      end
    endcase

    priority if (abort) begin
      mode_nxt        = jfd_pkg::MODE_HUNT;
      depth_nxt       = DEPTH_NONE;
      count_nxt       = jfd_pkg::COUNT_ZERO;
      res.frame_byte  = 8'h00;
      res.frame_first = 1'b0;
      res.frame_last  = 1'b1;
      res.frame_error = 1'b1;
    end else if (pass) begin
      count_nxt      = count_r + jfd_pkg::COUNT_ONE;
      res.frame_byte = rx_byte;
    end else begin
      count_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jfd_pkg::MODE_HUNT;
      depth_r <= DEPTH_NONE;
      brace_r <= 1'b0;
      count_r <= jfd_pkg::COUNT_ZERO;
    end else if (go) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      brace_r <= brace_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= jfd_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

endmodule

// ===== design/jfd_out_reg.sv =====
// Result register of the JSON frame delimiter: holds one frame byte and
// its marks until the receiver takes it. Depends on jfd_pkg.
module jfd_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  jfd_pkg::res_t res,
  output logic          room,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_frame_byte,
  output logic          out_frame_first,
  output logic          out_frame_last,
  output logic          out_frame_error
);

  logic          vld_r;
  logic          vld_nxt;
  jfd_pkg::res_t res_r;

  assign room    = !vld_r || !out_stall;
  assign vld_nxt = room ? load : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (room && load) begin
      res_r <= res;
    end
  end

  assign out_valid       = vld_r;
  assign out_frame_byte  = res_r.frame_byte;
  assign out_frame_first = res_r.frame_first;
  assign out_frame_last  = res_r.frame_last;
  assign out_frame_error = res_r.frame_error;

endmodule

// ===== design/json_frame_delimiter.sv =====
// JSON frame delimiter, top level: input register, scanner, result register.
// Depends on jfd_pkg, jfd_in_reg, jfd_scan and jfd_out_reg.
//
// Usage:
//   Input channel in_valid / in_rx_byte / in_stall carries the received
//   stream, one byte per transfer. Result channel out_valid / out_frame_* /
//   in out_stall carries frame bytes with first and last marks; an aborted
//   frame ends with one result carrying byte 0, last and error set.
//   cfg_wr_en / cfg_wr_data write the frame length limit; write while idle.
//   Path: a byte transferred in passes through the input register, then
//   the scanner and the result register, before it is offered at the output.
//   Throughput: one byte per cycle while the receiver does not stall, as
//   the scanner updates mode, depth and byte count for every byte taken.
//   Bytes dropped while hunting are taken in but give no result.
//   When the receiver stalls, the result holds and the input register
//   takes one more byte only if it is empty; further input then stalls.
//   Reset: hunting, depth and count cleared, limit 32 Mi bytes.
module json_frame_delimiter #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [jfd_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  input  logic [7:0]                  in_rx_byte,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_frame_byte,
  output logic                        out_frame_first,
  output logic                        out_frame_last,
  output logic                        out_frame_error
);

  logic          hold_vld;
  logic [7:0]    hold_byte;
  logic          room;
  logic          go;
  logic          res_vld;
  jfd_pkg::res_t res;

  assign go = hold_vld && room;

  jfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .advance    (go),
    .hold_vld   (hold_vld),
    .hold_byte  (hold_byte)
  );

  jfd_scan #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (go),
    .rx_byte     (hold_byte),
    .res_vld     (res_vld),
    .res         (res)
  );

  jfd_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (go && res_vld),
    .res             (res),
    .room            (room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_byte  (out_frame_byte),
    .out_frame_first (out_frame_first),
    .out_frame_last  (out_frame_last),
    .out_frame_error (out_frame_error)
  );

endmodule
